### hw/rtl/quicksort_engine_unit_assert.svh
// Assertion macros for the quicksort engine checker.
// Expect clk and rst_n in the scope where a macro is used.
`ifndef QUICKSORT_ENGINE_UNIT_ASSERT_SVH
`define QUICKSORT_ENGINE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/qse_pkg.sv
// Shared types and constants for the quicksort engine.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package qse_pkg;

  localparam int DATA_W  = 32;
  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = IDX_W + 1;
  localparam int STK_W   = 2 * IDX_W;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SORT_INIT,
    OP_POP_RD,
    OP_POP_LD,
    OP_PIV_RD,
    OP_PIV_LD,
    OP_SCAN_RD,
    OP_INC_S,
    OP_DEC_E,
    OP_SWAP_S,
    OP_SWAP_E,
    OP_FIN_RD,
    OP_FIN_LO,
    OP_FIN_E,
    OP_PUSH_HI,
    OP_PUSH_LO,
    OP_EMIT_INIT,
    OP_EMIT_RD,
    OP_EMIT_LD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic sp_zero;
    logic lo_lt_hi;
    logic s_le_e;
    logic s_gt_piv;
    logic e_gt_piv;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/qse_dp.sv
// Datapath of the quicksort engine: element store, range stack, partition
// pointers and output register. Executes one command from qse_ctrl per cycle.
// Depends on qse_pkg.
`default_nettype none

module qse_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qse_pkg::cmd_t              cmd,
  output qse_pkg::sts_t              sts,
  input  logic [qse_pkg::DATA_W-1:0] in_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [qse_pkg::DATA_W-1:0] out_data,
  output logic                       out_last
);

  logic [qse_pkg::DATA_W-1:0] elem_mem [qse_pkg::MAX_LEN];
  logic [qse_pkg::STK_W-1:0]  stk_mem  [qse_pkg::MAX_LEN];

  logic [qse_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [qse_pkg::CNT_W-1:0]  sp_r, sp_nxt;
  logic [qse_pkg::IDX_W-1:0]  lo_r, hi_r, e_r;
  logic [qse_pkg::CNT_W-1:0]  s_r;
  logic signed [qse_pkg::DATA_W-1:0] piv_r;
  logic [qse_pkg::DATA_W-1:0] rda_r, rdb_r;
  logic [qse_pkg::STK_W-1:0]  stk_rd_r;
  logic                       out_valid_r;
  logic [qse_pkg::DATA_W-1:0] out_data_r;
  logic                       out_last_r;

  logic                       mem_we;
  logic [qse_pkg::IDX_W-1:0]  mem_wa;
  logic [qse_pkg::DATA_W-1:0] mem_wd;
  logic                       rd_en;
  logic [qse_pkg::IDX_W-1:0]  ra, rb;
  logic                       stk_we;
  logic [qse_pkg::IDX_W-1:0]  stk_wa;
  logic [qse_pkg::STK_W-1:0]  stk_wd;

  logic [qse_pkg::CNT_W-1:0]  e_inc, lo_inc, s_inc, sp_dec;
  logic [qse_pkg::IDX_W-1:0]  e_dec, cnt_dec;
  logic                       stk_room, load_room, emit_last;

  assign e_inc     = {1'b0, e_r} + qse_pkg::CNT_W'(1);
  assign lo_inc    = {1'b0, lo_r} + qse_pkg::CNT_W'(1);
  assign s_inc     = s_r + qse_pkg::CNT_W'(1);
  assign sp_dec    = sp_r - qse_pkg::CNT_W'(1);
  assign e_dec     = e_r - qse_pkg::IDX_W'(1);
  assign cnt_dec   = qse_pkg::IDX_W'(count_r - qse_pkg::CNT_W'(1));
  assign stk_room  = sp_r < qse_pkg::CNT_W'(qse_pkg::MAX_LEN);
  assign load_room = count_r < qse_pkg::CNT_W'(qse_pkg::MAX_LEN);
  assign emit_last = s_inc == count_r;

  // Element store ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rda_r;
    rd_en  = 1'b0;
    ra     = lo_r;
    rb     = e_r;
    case (cmd.op)
      qse_pkg::OP_LOAD: begin
        mem_we = load_room;
        mem_wa = count_r[qse_pkg::IDX_W-1:0];
        mem_wd = in_data;
      end
      qse_pkg::OP_SWAP_S: begin
        mem_we = 1'b1;
        mem_wa = s_r[qse_pkg::IDX_W-1:0];
        mem_wd = rdb_r;
      end
      qse_pkg::OP_SWAP_E: begin
        mem_we = 1'b1;
        mem_wa = e_r;
        mem_wd = rda_r;
      end
      qse_pkg::OP_FIN_LO: begin
        mem_we = 1'b1;
        mem_wa = lo_r;
        mem_wd = rdb_r;
      end
      qse_pkg::OP_FIN_E: begin
        mem_we = 1'b1;
        mem_wa = e_r;
        mem_wd = rda_r;
      end
      qse_pkg::OP_PIV_RD: begin
        rd_en = 1'b1;
      end
      qse_pkg::OP_SCAN_RD: begin
        rd_en = 1'b1;
        ra    = s_r[qse_pkg::IDX_W-1:0];
      end
      qse_pkg::OP_FIN_RD: begin
        rd_en = 1'b1;
      end
      qse_pkg::OP_EMIT_RD: begin
        rd_en = 1'b1;
        ra    = s_r[qse_pkg::IDX_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Range stack write port; ranges of fewer than two elements are dropped
  always_comb begin
    stk_we = 1'b0;
    stk_wa = sp_r[qse_pkg::IDX_W-1:0];
    stk_wd = {lo_r, e_dec};
    case (cmd.op)
      qse_pkg::OP_SORT_INIT: begin
        stk_we = count_r >= qse_pkg::CNT_W'(2);
        stk_wa = '0;
        stk_wd = {qse_pkg::IDX_W'(0), cnt_dec};
      end
      qse_pkg::OP_PUSH_HI: begin
        stk_we = stk_room && (e_inc < {1'b0, hi_r});
        stk_wd = {e_inc[qse_pkg::IDX_W-1:0], hi_r};
      end
      qse_pkg::OP_PUSH_LO: begin
        stk_we = stk_room && (lo_inc < {1'b0, e_r});
      end
      default: begin
        stk_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    sp_nxt    = sp_r;
    case (cmd.op)
      qse_pkg::OP_LOAD: begin
        if (load_room) begin
          count_nxt = count_r + qse_pkg::CNT_W'(1);
        end
      end
      qse_pkg::OP_SORT_INIT: begin
        sp_nxt = stk_we ? qse_pkg::CNT_W'(1) : '0;
      end
      qse_pkg::OP_POP_RD: begin
        sp_nxt = sp_dec;
      end
      qse_pkg::OP_PUSH_HI, qse_pkg::OP_PUSH_LO: begin
        if (stk_we) begin
          sp_nxt = sp_r + qse_pkg::CNT_W'(1);
        end
      end
      qse_pkg::OP_EMIT_LD: begin
        if (emit_last) begin
          count_nxt = '0;
          sp_nxt    = '0;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rda_r <= elem_mem[ra];
      rdb_r <= elem_mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd.op == qse_pkg::OP_POP_RD) begin
      stk_rd_r <= stk_mem[sp_dec[qse_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sp_r    <= sp_nxt;
      if (cmd.op == qse_pkg::OP_EMIT_LD) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pointer and payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      qse_pkg::OP_POP_LD: begin
        lo_r <= stk_rd_r[qse_pkg::STK_W-1:qse_pkg::IDX_W];
        hi_r <= stk_rd_r[qse_pkg::IDX_W-1:0];
      end
      qse_pkg::OP_PIV_LD: begin
        piv_r <= rda_r;
        s_r   <= lo_inc;
        e_r   <= hi_r;
      end
      qse_pkg::OP_INC_S: begin
        s_r <= s_inc;
      end
      qse_pkg::OP_DEC_E: begin
        e_r <= e_dec;
      end
      qse_pkg::OP_EMIT_INIT: begin
        s_r <= '0;
      end
      qse_pkg::OP_EMIT_LD: begin
        s_r        <= s_inc;
        out_data_r <= rda_r;
        out_last_r <= emit_last;
      end
      default: begin
        s_r <= s_r;
      end
    endcase
  end

  assign sts.sp_zero   = sp_r == '0;
  assign sts.lo_lt_hi  = lo_r < hi_r;
  assign sts.s_le_e    = s_r <= {1'b0, e_r};
  assign sts.s_gt_piv  = $signed(rda_r) > piv_r;
  assign sts.e_gt_piv  = $signed(rdb_r) > piv_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.emit_last = emit_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/qse_ctrl.sv
// Controller of the quicksort engine: sequences load, partition and emit.
// Drives qse_dp through cmd_t and reads back sts_t. Depends on qse_pkg.
`default_nettype none

module qse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  qse_pkg::sts_t sts,
  output qse_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_POP,
    ST_POP_LD,
    ST_RANGE,
    ST_PIV_LD,
    ST_SCAN,
    ST_CMP,
    ST_SWAP_E,
    ST_FIN_LO,
    ST_FIN_E,
    ST_PUSH_HI,
    ST_PUSH_LO,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = qse_pkg::OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = qse_pkg::OP_LOAD;
          if (in_last) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.op    = qse_pkg::OP_SORT_INIT;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (sts.sp_zero) begin
          cmd.op    = qse_pkg::OP_EMIT_INIT;
          state_nxt = ST_EMIT_RD;
        end else begin
          cmd.op    = qse_pkg::OP_POP_RD;
          state_nxt = ST_POP_LD;
        end
      end
      ST_POP_LD: begin
        cmd.op    = qse_pkg::OP_POP_LD;
        state_nxt = ST_RANGE;
      end
      ST_RANGE: begin
        if (sts.lo_lt_hi) begin
          cmd.op    = qse_pkg::OP_PIV_RD;
          state_nxt = ST_PIV_LD;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_PIV_LD: begin
        cmd.op    = qse_pkg::OP_PIV_LD;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.s_le_e) begin
          cmd.op    = qse_pkg::OP_SCAN_RD;
          state_nxt = ST_CMP;
        end else begin
          cmd.op    = qse_pkg::OP_FIN_RD;
          state_nxt = ST_FIN_LO;
        end
      end
      ST_CMP: begin
        // advance the low pointer first, then the high one, else exchange
        if (!sts.s_gt_piv) begin
          cmd.op    = qse_pkg::OP_INC_S;
          state_nxt = ST_SCAN;
        end else if (sts.e_gt_piv) begin
          cmd.op    = qse_pkg::OP_DEC_E;
          state_nxt = ST_SCAN;
        end else begin
          cmd.op    = qse_pkg::OP_SWAP_S;
          state_nxt = ST_SWAP_E;
        end
      end
      ST_SWAP_E: begin
        cmd.op    = qse_pkg::OP_SWAP_E;
        state_nxt = ST_SCAN;
      end
      ST_FIN_LO: begin
        cmd.op    = qse_pkg::OP_FIN_LO;
        state_nxt = ST_FIN_E;
      end
      ST_FIN_E: begin
        cmd.op    = qse_pkg::OP_FIN_E;
        state_nxt = ST_PUSH_HI;
      end
      ST_PUSH_HI: begin
        cmd.op    = qse_pkg::OP_PUSH_HI;
        state_nxt = ST_PUSH_LO;
      end
      ST_PUSH_LO: begin
        cmd.op    = qse_pkg::OP_PUSH_LO;
        state_nxt = ST_POP;
      end
      ST_EMIT_RD: begin
        cmd.op    = qse_pkg::OP_EMIT_RD;
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        // hold until the output register can take the next transfer
        if (sts.out_free) begin
          cmd.op    = qse_pkg::OP_EMIT_LD;
          state_nxt = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == ST_IDLE;

endmodule

`default_nettype wire

### hw/rtl/quicksort_engine_unit.sv
// Quicksort engine: loads a batch, sorts it in place, streams it out ascending.
// Load takes one item per cycle while idle. Sort: each range popped from the stack
// is partitioned by reading and comparing the scan pair with the pivot, exchanging
// pairs out of place, and pushing both halves back. Emit holds while the output stalls.
// Synchronous active-low reset empties the batch and stack.
// Depends on qse_pkg, qse_ctrl and qse_dp.
`default_nettype none

module quicksort_engine_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [qse_pkg::DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [qse_pkg::DATA_W-1:0] out_tdata,  // [31:0] sorted_value
  output logic                       out_tlast
);

  qse_pkg::cmd_t cmd;
  qse_pkg::sts_t sts;

  qse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qse_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

### hw/rtl/qse_checker.sv
// Port-level checker for the quicksort engine, bound to the top level.
// Depends on quicksort_engine_unit_assert.svh.
`default_nettype none
`include "quicksort_engine_unit_assert.svh"

module qse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  `QSE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output changed")
  `QSE_ASSERT_IMP(a_no_load_mid_batch, out_tvalid && !out_tlast, !in_tready, "input taken while a batch streams out")
  `QSE_ASSERT_NXT(a_sort_after_last, in_tvalid && in_tready && in_tlast, !in_tready, "input taken right after end of batch")
  `QSE_ASSERT_NXT(a_quiet_after_last, out_tvalid && out_tready && out_tlast, !out_tvalid, "output after final sorted element")

endmodule

bind quicksort_engine_unit qse_checker u_chk (.*);

`default_nettype wire
